### hdl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while rst is high
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, skipped while rst is high
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

### hdl/apad_pkg.sv
// ----------------------------------------------------------------------------
// apad_pkg
// shared types and constants of the adaptive predictive audio decoder
// ----------------------------------------------------------------------------
package apad_pkg;

   // request and response payloads
   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_stream;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               right_channel;
      logic               stream_done;
      logic               decode_error;
      logic               last_of_byte;
   } rsp_payload_type;

   // register indexes
   localparam logic [1:0] CSR_STEREO_MODE  = 2'd0;
   localparam logic [1:0] CSR_OUTPUT_SHIFT = 2'd1;
   localparam logic [1:0] CSR_FRAME_LIMIT  = 2'd2;

   localparam logic [31:0] STEP_BIAS   = 32'h24;
   localparam logic [2:0]  ZERO_GROUP  = 3'd7;
   localparam int          NUM_ORDERS  = 5;

   typedef enum logic [1:0] {
      PH_UNARY,
      PH_EXTRA,
      PH_TAIL
   } phase_type;

   // what the current bit does
   typedef enum logic [2:0] {
      OC_SKIP,
      OC_OPEN,
      OC_NEXT,
      OC_FAIL,
      OC_RANGE,
      OC_FINISH
   } outcome_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_OPEN,
      CMD_SCAN,
      CMD_STEP,
      CMD_BIT,
      CMD_RANGE,
      CMD_FSTART,
      CMD_DOWN,
      CMD_UPINIT,
      CMD_UP,
      CMD_ENERGY,
      CMD_RESULT,
      CMD_ADV,
      CMD_FLUSH
   } cmd_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BIT,
      ST_SCAN,
      ST_STEP,
      ST_RANGE,
      ST_FSTART,
      ST_DOWN,
      ST_UP,
      ST_RES,
      ST_ADV,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      cmd_op_type op;
   } cmd_type;

   typedef struct packed {
      outcome_type outcome;
      logic        scan_last;
      logic        idx_zero;
      logic        idx_four;
      logic        rs_fail;
      logic        rs_done;
      logic        rs_nbpos;
      logic        last_bit;
      logic        slot_free;
      logic        pend_valid;
   } status_type;

endpackage

### hdl/adaptive_predictive_audio_decoder_top.sv
// ----------------------------------------------------------------------------
// adaptive_predictive_audio_decoder_top
// bit-serial decoder of adaptive predictive compressed audio
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one compressed byte per request; start_of_stream clears the
//   predictor and parser state before that byte is parsed. rsp_* returns the
//   decoded samples, zero to eight per byte, last_of_byte marking the final
//   one. csr_* writes stereo_mode, output_shift and frame_limit; the user
//   must write them only while idle, which the block does not enforce.
// Flow:
//   a byte is accepted, parsed bit by bit and flushed; a sample is opened
//   (energy scan and step), range fitted and finished (difference chain,
//   energies, result). One byte at a time. A result waits in a holding
//   register until the next one is found or the byte ends.
// Reset and stall:
//   synchronous reset clears the stream state and the registers to defaults,
//   except the working payload registers, which it leaves as they are. A
//   stalled result holds in the output register; one more result can wait
//   in a holding register, after which parsing pauses until rsp_ready.
// ----------------------------------------------------------------------------
module adaptive_predictive_audio_decoder_top #(
   parameter int UNARY_LIMIT  = 50000,
   parameter int ENERGY_START = 2560
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  apad_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output apad_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [23:0]               csr_wdata
);
   import apad_pkg::*;

   cmd_type    cmd;
   status_type status;

   // registers are always writable
   assign csr_ready = 1'b1;

   apad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   apad_datapath #(
      .UNARY_LIMIT  (UNARY_LIMIT),
      .ENERGY_START (ENERGY_START)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

### hdl/apad_ctrl.sv
// ----------------------------------------------------------------------------
// apad_ctrl
// sequencer that walks each byte bit by bit and steps the datapath
// ----------------------------------------------------------------------------
module apad_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  apad_pkg::status_type status,
   output apad_pkg::cmd_type    cmd
);
   import apad_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_BIT;
         end
         ST_BIT: begin
            unique case (status.outcome)
               OC_SKIP, OC_NEXT: state_in = ST_ADV;
               OC_OPEN:          state_in = ST_SCAN;
               OC_FAIL:          state_in = ST_RES;
               OC_RANGE:         state_in = ST_RANGE;
               OC_FINISH:        state_in = ST_FSTART;
               default:          state_in = ST_ADV;
            endcase
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_STEP;
         end
         ST_STEP:   state_in = ST_BIT;
         ST_RANGE: begin
            if (status.rs_fail) begin
               state_in = ST_RES;
            end else if (status.rs_done) begin
               state_in = status.rs_nbpos ? ST_ADV : ST_FSTART;
            end
         end
         ST_FSTART: state_in = ST_DOWN;
         ST_DOWN: begin
            if (status.idx_zero) state_in = ST_UP;
         end
         ST_UP: begin
            if (status.idx_four) state_in = ST_RES;
         end
         ST_RES: begin
            if (!status.pend_valid || status.slot_free) state_in = ST_ADV;
         end
         ST_ADV: begin
            state_in = status.last_bit ? ST_FLUSH : ST_BIT;
         end
         ST_FLUSH: begin
            if (!status.pend_valid || status.slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd.op    = CMD_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = CMD_LOAD;
         end
         ST_BIT: begin
            unique case (status.outcome)
               OC_SKIP: cmd.op = CMD_NONE;
               OC_OPEN: cmd.op = CMD_OPEN;
               default: cmd.op = CMD_BIT;
            endcase
         end
         ST_SCAN:   cmd.op = CMD_SCAN;
         ST_STEP:   cmd.op = CMD_STEP;
         ST_RANGE:  cmd.op = CMD_RANGE;
         ST_FSTART: cmd.op = CMD_FSTART;
         ST_DOWN:   cmd.op = status.idx_zero ? CMD_UPINIT : CMD_DOWN;
         ST_UP:     cmd.op = status.idx_four ? CMD_ENERGY : CMD_UP;
         ST_RES: begin
            if (!status.pend_valid || status.slot_free) cmd.op = CMD_RESULT;
         end
         ST_ADV:    cmd.op = CMD_ADV;
         ST_FLUSH: begin
            if (status.pend_valid && status.slot_free) cmd.op = CMD_FLUSH;
         end
         default:   cmd.op = CMD_NONE;
      endcase
   end

endmodule

### hdl/apad_datapath.sv
// ----------------------------------------------------------------------------
// apad_datapath
// predictor state, bit parser, range fitting and result registers
// ----------------------------------------------------------------------------
module apad_datapath #(
   parameter int UNARY_LIMIT  = 50000,
   parameter int ENERGY_START = 2560
) (
   input  logic                      clock,
   input  logic                      reset,
   input  apad_pkg::req_payload_type req_data,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output apad_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_valid,
   input  logic [1:0]                csr_index,
   input  logic [23:0]               csr_wdata,
   input  apad_pkg::cmd_type         cmd,
   output apad_pkg::status_type      status
);
   import apad_pkg::*;

   localparam logic [15:0] ULIM   = 16'(UNARY_LIMIT);
   localparam logic [31:0] E_INIT = 32'(ENERGY_START);

   // configuration
   logic        stereo_ff, stereo_in;
   logic [4:0]  oshift_ff, oshift_in;
   logic [23:0] flimit_ff, flimit_in;

   // stream state
   logic [31:0]        sums_ff  [2][NUM_ORDERS];
   logic [31:0]        sums_in  [2][NUM_ORDERS];
   logic [31:0]        energ_ff [2][NUM_ORDERS];
   logic [31:0]        energ_in [2][NUM_ORDERS];
   logic [31:0]        old_ff   [NUM_ORDERS];
   logic [31:0]        old_in   [NUM_ORDERS];
   logic [31:0]        range_ff [2];
   logic [31:0]        range_in [2];
   logic signed [5:0]  nb_ff    [2];
   logic signed [5:0]  nb_in    [2];
   phase_type          phase_ff, phase_in;
   logic [31:0]        q_ff, q_in, step_ff, step_in, erd_ff, erd_in;
   logic [31:0]        lhold_ff, lhold_in, emin_ff, emin_in;
   logic [31:0]        t_ff, t_in, rem_ff, rem_in;
   logic [2:0]         zgc_ff, zgc_in;
   logic [15:0]        ul_ff, ul_in;
   logic [23:0]        frames_ff, frames_in;
   logic               chsel_ff, chsel_in, halted_ff, halted_in, open_ff, open_in;
   logic               cur_ch_ff, cur_ch_in, cur_st_ff, cur_st_in;
   logic               grow_ff, grow_in, err_ff, err_in;
   logic [4:0]         bdue_ff, bdue_in;
   logic [7:0]         byte_ff, byte_in;
   logic [2:0]         bidx_ff, bidx_in, k_ff, k_in, idx_ff, idx_in;

   // result registers
   logic            pend_valid_ff, pend_valid_in, out_valid_ff, out_valid_in;
   rsp_payload_type pend_ff, pend_in, out_ff, out_in;

   // shared terms
   logic        ch, bit_cur, slot_free;
   logic [31:0] co, erd_n, r2, t2, rng_new, scan_e, s0, s0h, outv, sum_lr;
   logic [31:0] val, dval, tail_rem;
   logic [4:0]  bd_n, esh;
   logic signed [5:0] nb_step;
   logic        rs_fail, rs_done;
   logic [23:0] frames_n;
   logic        fin_done;
   outcome_type outcome;

   always_comb begin
      ch       = cur_ch_ff;
      bit_cur  = byte_ff[bidx_ff];
      co       = range_ff[ch] - step_ff;
      erd_n    = {erd_ff[30:0], bit_cur};
      bd_n     = bdue_ff - 5'd1;
      tail_rem = co + ((erd_ff - co) << 1) + {31'd0, bit_cur};
      slot_free = !out_valid_ff || rsp_ready;
      scan_e   = energ_ff[ch][idx_ff];
      // one range fitting step
      r2 = range_ff[ch] << 1;
      t2 = t_ff >> 1;
      if (grow_ff) begin
         rng_new = r2;
         nb_step = nb_ff[ch] + 6'sd1;
         rs_fail = (r2 == 32'd0);
         rs_done = (step_ff < r2);
      end else begin
         rng_new = t_ff;
         nb_step = nb_ff[ch] - 6'sd1;
         rs_fail = 1'b0;
         rs_done = (step_ff >= t2);
      end
      // finished value, bitwise inverted when its low bit is set
      val  = q_ff + rem_ff;
      dval = val ^ {32{val[0]}};
      // output sample
      s0     = sums_ff[ch][0];
      s0h    = 32'($signed(s0) >>> 1);
      esh    = (oshift_ff == 5'd0) ? 5'd0 : oshift_ff - 5'd1;
      sum_lr = lhold_ff + s0h;
      if (!cur_st_ff) begin
         outv = 32'($signed(s0) >>> oshift_ff);
      end else if (!ch) begin
         outv = 32'($signed(s0h) >>> esh);
      end else begin
         outv = 32'($signed(sum_lr) >>> esh);
      end
      frames_n = frames_ff + 24'd1;
      fin_done = (!cur_st_ff || ch) && (flimit_ff != 24'd0) && (frames_n == flimit_ff);
   end

   // bit classification
   always_comb begin
      if (halted_ff) begin
         outcome = OC_SKIP;
      end else if (!open_ff) begin
         outcome = OC_OPEN;
      end else begin
         case (phase_ff)
            PH_UNARY: begin
               if (bit_cur)             outcome = OC_RANGE;
               else if (ul_ff >= ULIM)  outcome = OC_FAIL;
               else                     outcome = OC_NEXT;
            end
            PH_EXTRA: begin
               if (bd_n != 5'd0)        outcome = OC_NEXT;
               else if (erd_n < co)     outcome = OC_FINISH;
               else                     outcome = OC_NEXT;
            end
            default:                    outcome = OC_FINISH;
         endcase
      end
   end

   always_comb begin
      status.outcome    = outcome;
      status.scan_last  = (idx_ff == 3'd4);
      status.idx_zero   = (idx_ff == 3'd0);
      status.idx_four   = (idx_ff == 3'd4);
      status.rs_fail    = rs_fail;
      status.rs_done    = rs_done;
      status.rs_nbpos   = (nb_step > 6'sd0);
      status.last_bit   = (bidx_ff == 3'd0);
      status.slot_free  = slot_free;
      status.pend_valid = pend_valid_ff;
   end

   // next state of everything
   always_comb begin
      stereo_in = stereo_ff;  oshift_in = oshift_ff;  flimit_in = flimit_ff;
      sums_in = sums_ff;  energ_in = energ_ff;  old_in = old_ff;
      range_in = range_ff;  nb_in = nb_ff;  phase_in = phase_ff;
      q_in = q_ff;  step_in = step_ff;  erd_in = erd_ff;  lhold_in = lhold_ff;
      emin_in = emin_ff;  t_in = t_ff;  rem_in = rem_ff;  zgc_in = zgc_ff;
      ul_in = ul_ff;  frames_in = frames_ff;  chsel_in = chsel_ff;
      halted_in = halted_ff;  open_in = open_ff;  cur_ch_in = cur_ch_ff;
      cur_st_in = cur_st_ff;  grow_in = grow_ff;  err_in = err_ff;
      bdue_in = bdue_ff;  byte_in = byte_ff;  bidx_in = bidx_ff;
      k_in = k_ff;  idx_in = idx_ff;
      pend_valid_in = pend_valid_ff;  pend_in = pend_ff;  out_in = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      // register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_STEREO_MODE:  stereo_in = csr_wdata[0];
            CSR_OUTPUT_SHIFT: oshift_in = csr_wdata[4:0];
            CSR_FRAME_LIMIT:  flimit_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (cmd.op)
         CMD_LOAD: begin
            byte_in = req_data.data_byte;
            bidx_in = 3'd7;
            if (req_data.start_of_stream) begin
               for (int c = 0; c < 2; c++) begin
                  for (int j = 0; j < NUM_ORDERS; j++) begin
                     sums_in[c][j]  = 32'd0;
                     energ_in[c][j] = E_INIT;
                  end
                  range_in[c] = 32'd2;
                  nb_in[c]    = 6'sd0;
               end
               phase_in = PH_UNARY;  q_in = 32'd0;  step_in = 32'd0;
               zgc_in = ZERO_GROUP;  ul_in = 16'd0;  erd_in = 32'd0;
               lhold_in = 32'd0;  chsel_in = 1'b0;  frames_in = 24'd0;
               halted_in = 1'b0;  open_in = 1'b0;  cur_ch_in = 1'b0;
               cur_st_in = 1'b0;  bdue_in = 5'd0;
            end
         end
         CMD_OPEN: begin
            cur_st_in = stereo_ff;
            cur_ch_in = stereo_ff ? chsel_ff : 1'b0;
            q_in = 32'd0;  zgc_in = ZERO_GROUP;  ul_in = 16'd0;  erd_in = 32'd0;
            phase_in = PH_UNARY;  open_in = 1'b1;  idx_in = 3'd0;
         end
         CMD_SCAN: begin
            // first lowest wins
            if (idx_ff == 3'd0 || scan_e < emin_ff) begin
               emin_in = scan_e;
               k_in    = idx_ff;
            end
            idx_in = idx_ff + 3'd1;
         end
         CMD_STEP: begin
            step_in = ({emin_ff[30:0], 1'b0} + emin_ff + STEP_BIAS) >> 7;
         end
         CMD_BIT: begin
            case (phase_ff)
               PH_UNARY: begin
                  if (bit_cur) begin
                     grow_in = (step_ff >= range_ff[ch]);
                     if (step_ff < range_ff[ch]) begin
                        t_in      = range_ff[ch];
                        nb_in[ch] = nb_ff[ch] + 6'sd1;
                     end
                  end else if (ul_ff >= ULIM) begin
                     err_in = 1'b1;
                  end else begin
                     q_in  = q_ff + step_ff;
                     ul_in = ul_ff + 16'd1;
                     if (zgc_ff == 3'd1) begin
                        step_in = step_ff << 2;
                        zgc_in  = ZERO_GROUP;
                     end else begin
                        zgc_in = zgc_ff - 3'd1;
                     end
                  end
               end
               PH_EXTRA: begin
                  erd_in  = erd_n;
                  bdue_in = bd_n;
                  if (bd_n == 5'd0) begin
                     if (erd_n < co) rem_in = erd_n;
                     else            phase_in = PH_TAIL;
                  end
               end
               default: rem_in = tail_rem;
            endcase
         end
         CMD_RANGE: begin
            if (rs_fail) begin
               range_in[ch] = 32'd0;
               err_in       = 1'b1;
            end else begin
               range_in[ch] = rng_new;
               nb_in[ch]    = nb_step;
               t_in         = t2;
               if (rs_done) begin
                  if (nb_step > 6'sd0) begin
                     phase_in = PH_EXTRA;
                     bdue_in  = nb_step[4:0];
                     erd_in   = 32'd0;
                  end else begin
                     rem_in = 32'd0;
                  end
               end
            end
         end
         CMD_FSTART: begin
            old_in = sums_ff[ch];
            sums_in[ch][k_ff] = dval;
            idx_in = k_ff;
            err_in = 1'b0;
         end
         CMD_DOWN: begin
            // sums below the chosen order, one per cycle
            for (int j = 0; j < NUM_ORDERS - 1; j++) begin
               if (3'(j + 1) == idx_ff) sums_in[ch][j] = old_ff[j] + sums_ff[ch][j + 1];
            end
            idx_in = idx_ff - 3'd1;
         end
         CMD_UPINIT: idx_in = k_ff;
         CMD_UP: begin
            // sums above the chosen order, one per cycle
            for (int j = 1; j < NUM_ORDERS; j++) begin
               if (3'(j - 1) == idx_ff) sums_in[ch][j] = sums_ff[ch][j - 1] - old_ff[j - 1];
            end
            idx_in = idx_ff + 3'd1;
         end
         CMD_ENERGY: begin
            for (int j = 0; j < NUM_ORDERS; j++) begin
               energ_in[ch][j] = energ_ff[ch][j]
                  + (sums_ff[ch][j] ^ {32{sums_ff[ch][j][31]}})
                  - (energ_ff[ch][j] >> 5);
            end
         end
         CMD_RESULT: begin
            if (pend_valid_ff) begin
               out_in       = pend_ff;
               out_valid_in = 1'b1;
            end
            pend_valid_in = 1'b1;
            open_in  = 1'b0;
            phase_in = PH_UNARY;
            pend_in.right_channel = cur_st_ff ? ch : 1'b0;
            pend_in.last_of_byte  = 1'b0;
            if (err_ff) begin
               pend_in.sample       = 16'sd0;
               pend_in.stream_done  = 1'b0;
               pend_in.decode_error = 1'b1;
               halted_in = 1'b1;
            end else begin
               pend_in.sample       = outv[15:0];
               pend_in.stream_done  = fin_done;
               pend_in.decode_error = 1'b0;
               if (fin_done) halted_in = 1'b1;
               if (!cur_st_ff || ch) frames_in = frames_n;
               if (cur_st_ff) begin
                  chsel_in = !ch;
                  if (!ch) lhold_in = s0h;
               end
            end
         end
         CMD_ADV: bidx_in = bidx_ff - 3'd1;
         CMD_FLUSH: begin
            out_in = pend_ff;
            out_in.last_of_byte = 1'b1;
            out_valid_in  = 1'b1;
            pend_valid_in = 1'b0;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_ff <= 1'b0;  oshift_ff <= 5'd1;  flimit_ff <= 24'd0;
         phase_ff <= PH_UNARY;  zgc_ff <= ZERO_GROUP;  ul_ff <= 16'd0;
         frames_ff <= 24'd0;  chsel_ff <= 1'b0;  halted_ff <= 1'b0;
         open_ff <= 1'b0;  cur_ch_ff <= 1'b0;  cur_st_ff <= 1'b0;
         bdue_ff <= 5'd0;  pend_valid_ff <= 1'b0;  out_valid_ff <= 1'b0;
         q_ff <= 32'd0;  step_ff <= 32'd0;  erd_ff <= 32'd0;  lhold_ff <= 32'd0;
         for (int c = 0; c < 2; c++) begin
            for (int j = 0; j < NUM_ORDERS; j++) begin
               sums_ff[c][j]  <= 32'd0;
               energ_ff[c][j] <= E_INIT;
            end
            range_ff[c] <= 32'd2;
            nb_ff[c]    <= 6'sd0;
         end
      end else begin
         stereo_ff <= stereo_in;  oshift_ff <= oshift_in;  flimit_ff <= flimit_in;
         phase_ff <= phase_in;  zgc_ff <= zgc_in;  ul_ff <= ul_in;
         frames_ff <= frames_in;  chsel_ff <= chsel_in;  halted_ff <= halted_in;
         open_ff <= open_in;  cur_ch_ff <= cur_ch_in;  cur_st_ff <= cur_st_in;
         bdue_ff <= bdue_in;  pend_valid_ff <= pend_valid_in;
         out_valid_ff <= out_valid_in;
         q_ff <= q_in;  step_ff <= step_in;  erd_ff <= erd_in;  lhold_ff <= lhold_in;
         sums_ff <= sums_in;  energ_ff <= energ_in;
         range_ff <= range_in;  nb_ff <= nb_in;
      end
   end

   // working payload registers
   always_ff @(posedge clock) begin
      old_ff <= old_in;  emin_ff <= emin_in;  t_ff <= t_in;  rem_ff <= rem_in;
      grow_ff <= grow_in;  err_ff <= err_in;  byte_ff <= byte_in;
      bidx_ff <= bidx_in;  k_ff <= k_in;  idx_ff <= idx_in;
      pend_ff <= pend_in;  out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

### hdl/apad_checker.sv
// ----------------------------------------------------------------------------
// apad_checker
// port-level checks of the decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apad_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input apad_pkg::rsp_payload_type rsp_data
);
   import apad_pkg::*;

   // stalled response holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response dropped or changed while stalled")

   // nothing left over from before reset
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "response valid right after reset")

   // one request at a time
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "request taken while parsing")

   // error results carry no sample and no done flag
   `ASSERT_IMPLIES(a_error_clean, clock, reset, rsp_valid && rsp_data.decode_error, rsp_data.sample == 16'sd0 && !rsp_data.stream_done, "malformed error result")

endmodule

bind adaptive_predictive_audio_decoder_top apad_checker u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the adaptive predictive audio decoder: a bit-level
// predictor of the decoder runs beside the block, every byte request is
// predicted on acceptance and every returned sample is compared in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import apad_pkg::*;

   localparam int UNARY_MAX   = 50000;
   localparam int ENERGY_INIT = 2560;
   localparam int QUIET_LIMIT = 20000;
   localparam int SETTLE      = 200;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [1:0]      csr_index = '0;
   logic [23:0]     csr_wdata = '0;

   adaptive_predictive_audio_decoder_top #(
      .UNARY_LIMIT  (UNARY_MAX),
      .ENERGY_START (ENERGY_INIT)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder model state
   logic [31:0] dsum [10];
   logic [31:0] energy [10];
   logic [31:0] range_val [2];
   int          range_bits [2];
   phase_type   phase;
   logic [31:0] quot, step_val, unary_len, extra_val, left_val;
   int          zero_grp, bits_left;
   logic [23:0] frame_count;
   bit          chan_sel, halted, in_sample, samp_chan, samp_stereo;

   // register shadow
   bit          reg_stereo = 1'b0;
   logic [4:0]  reg_shift = 5'd1;
   logic [23:0] reg_limit = '0;

   rsp_payload_type pending_samples [$];
   int  error_count = 0;
   bit  idle_on = 1'b1;
   int  rsp_hold_len = 0;

   function automatic logic [31:0] asr(logic [31:0] x, logic [4:0] s);
      return $signed(x) >>> s;
   endfunction

   function automatic int lowest_order(bit ch);
      int p;
      p = 0;
      for (int i = 1; i < NUM_ORDERS; i++)
         if (energy[ch*5+i] < energy[ch*5+p]) p = i;
      return p;
   endfunction

   function automatic void clear_stream();
      for (int i = 0; i < 10; i++) begin
         dsum[i] = '0;
         energy[i] = ENERGY_INIT;
      end
      range_val[0] = 2; range_val[1] = 2;
      range_bits[0] = 0; range_bits[1] = 0;
      phase = PH_UNARY;
      quot = 0; step_val = 0; zero_grp = 7; unary_len = 0; extra_val = 0;
      left_val = 0; chan_sel = 0; frame_count = '0; halted = 0;
      in_sample = 0; samp_chan = 0; samp_stereo = 0; bits_left = 0;
   endfunction

   function automatic rsp_payload_type make_sample(logic [31:0] v, bit rc, bit dn, bit er);
      rsp_payload_type r;
      r.sample = v[15:0];
      r.right_channel = rc;
      r.stream_done = dn;
      r.decode_error = er;
      r.last_of_byte = 1'b0;
      return r;
   endfunction

   function automatic rsp_payload_type error_sample();
      halted = 1;
      in_sample = 0;
      return make_sample(0, samp_stereo ? samp_chan : 1'b0, 1'b0, 1'b1);
   endfunction

   // close the open sample: difference chain, energies, output value
   function automatic rsp_payload_type close_sample(logic [31:0] rem);
      logic [31:0] val, d, s0h, outv, a;
      logic [31:0] old [5];
      logic [4:0]  esh;
      int          base, k;
      bit          done;
      val  = quot + rem;
      d    = val[0] ? ~val : val;
      base = samp_chan * 5;
      k    = lowest_order(samp_chan);
      done = 0;
      for (int j = 0; j < 5; j++) old[j] = dsum[base+j];
      dsum[base+k] = d;
      for (int j = k - 1; j >= 0; j--) dsum[base+j] = old[j] + dsum[base+j+1];
      for (int j = k + 1; j < 5; j++) dsum[base+j] = dsum[base+j-1] - old[j-1];
      for (int j = 0; j < 5; j++) begin
         a = dsum[base+j][31] ? ~dsum[base+j] : dsum[base+j];
         energy[base+j] = energy[base+j] + a - (energy[base+j] >> 5);
      end
      s0h = asr(dsum[base], 5'd1);
      esh = (reg_shift != 0) ? reg_shift - 5'd1 : 5'd0;
      if (!samp_stereo) begin
         outv = asr(dsum[base], reg_shift);
         frame_count++;
         done = 1;
      end else if (samp_chan == 0) begin
         left_val = s0h;
         outv = asr(s0h, esh);
         chan_sel = 1;
      end else begin
         outv = asr(left_val + s0h, esh);
         chan_sel = 0;
         frame_count++;
         done = 1;
      end
      done = done && reg_limit != 0 && frame_count == reg_limit;
      if (done) halted = 1;
      in_sample = 0;
      phase = PH_UNARY;
      return make_sample(outv, samp_stereo ? samp_chan : 1'b0, done, 1'b0);
   endfunction

   // one compressed bit; returns 1 when a sample comes out
   function automatic bit decode_bit(bit b, output rsp_payload_type r);
      logic [31:0] cs, co, t;
      int          nb, p;
      r = '0;
      if (halted) return 0;
      if (!in_sample) begin
         samp_stereo = reg_stereo;
         samp_chan = samp_stereo ? chan_sel : 1'b0;
         p = lowest_order(samp_chan);
         step_val = (energy[samp_chan*5+p] * 3 + STEP_BIAS) >> 7;
         quot = 0; zero_grp = ZERO_GROUP; unary_len = 0; extra_val = 0;
         phase = PH_UNARY;
         in_sample = 1;
      end
      if (phase == PH_UNARY) begin
         cs = step_val;
         if (!b) begin
            quot += cs;
            zero_grp--;
            if (zero_grp == 0) begin
               step_val = cs << 2;
               zero_grp = ZERO_GROUP;
            end
            if (unary_len >= UNARY_MAX) begin
               r = error_sample();
               return 1;
            end
            unary_len++;
            return 0;
         end
         nb = range_bits[samp_chan];
         if (cs >= range_val[samp_chan]) begin
            while (cs >= range_val[samp_chan]) begin
               range_val[samp_chan] <<= 1;
               if (range_val[samp_chan] == 0) begin
                  r = error_sample();
                  return 1;
               end
               nb++;
            end
         end else begin
            t = range_val[samp_chan];
            nb++;
            forever begin
               range_val[samp_chan] = t;
               t >>= 1;
               nb--;
               if (cs >= t) break;
            end
         end
         range_bits[samp_chan] = nb;
         extra_val = 0;
         if (nb > 0) begin
            bits_left = nb;
            phase = PH_EXTRA;
            return 0;
         end
         r = close_sample(0);
         return 1;
      end
      co = range_val[samp_chan] - step_val;
      if (phase == PH_EXTRA) begin
         extra_val = (extra_val << 1) | b;
         bits_left--;
         if (bits_left > 0) return 0;
         if (extra_val < co) begin
            r = close_sample(extra_val);
            return 1;
         end
         phase = PH_TAIL;
         return 0;
      end
      r = close_sample(co + (extra_val - co) * 2 + b);
      return 1;
   endfunction

   function automatic void predict_request(req_payload_type q);
      rsp_payload_type r;
      int n;
      n = 0;
      if (q.start_of_stream) clear_stream();
      for (int i = 7; i >= 0; i--) begin
         if (decode_bit(q.data_byte[i], r)) begin
            if (n > 0) pending_samples.push_back(r);
            else pending_samples.push_back(r);
            n++;
         end
      end
      if (n > 0) pending_samples[$].last_of_byte = 1'b1;
   endfunction

   // send one byte request
   task automatic send_byte(logic [7:0] d, bit sos);
      int gap;
      gap = idle_on ? $urandom_range(0, 18) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data.data_byte <= d;
      req_data.start_of_stream <= sos;
      do @(posedge clock); while (!req_ready);
      predict_request(req_data);
   endtask

   task automatic end_requests();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // wait for every sample, then let a trailing byte finish parsing
   task automatic drain();
      end_requests();
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [23:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_STEREO_MODE:  reg_stereo = val[0];
         CSR_OUTPUT_SHIFT: reg_shift = val[4:0];
         CSR_FRAME_LIMIT:  reg_limit = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic setup(bit st, logic [4:0] sh, logic [23:0] lim);
      drain();
      write_reg(CSR_STEREO_MODE, {23'd0, st});
      write_reg(CSR_OUTPUT_SHIFT, {19'd0, sh});
      write_reg(CSR_FRAME_LIMIT, lim);
   endtask

   // random bytes, restarting the stream now and then, more often after a halt
   task automatic random_bytes(int n);
      bit sos;
      for (int i = 0; i < n; i++) begin
         sos = ($urandom_range(0, 24) == 0) || (halted && $urandom_range(0, 2) == 0);
         send_byte(8'($urandom_range(0, 255)), sos);
      end
   endtask

   task automatic test_byte_extremes();
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hAA, 1'b1);
      send_byte(8'h55, 1'b0);
   endtask

   task automatic test_shift_and_stereo();
      setup(1'b1, 5'd1, 24'd0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h3C, 1'b0);
      setup(1'b1, 5'd31, 24'd0);
      send_byte(8'h96, 1'b0);
      setup(1'b0, 5'd31, 24'd0);
      send_byte(8'h5A, 1'b0);
      setup(1'b1, 5'd0, 24'd0);
      send_byte(8'hE7, 1'b0);
      setup(1'b0, 5'd0, 24'd0);
      send_byte(8'h7E, 1'b1);
      drain();
      write_reg(2'd3, 24'hFFFFFF);
   endtask

   task automatic test_frame_limit();
      setup(1'b0, 5'd1, 24'd3);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);
      setup(1'b1, 5'd2, 24'd2);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      setup(1'b0, 5'd1, 24'hFFFFFF);
      send_byte(8'hC3, 1'b0);
   endtask

   task automatic test_range_overflow();
      setup(1'b0, 5'd1, 24'd0);
      send_byte(8'h00, 1'b1);
      for (int i = 0; i < 10; i++) send_byte(8'h00, 1'b0);
      send_byte(8'h08, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   // long zero run back to back, step growth past the word width
   task automatic test_unary_limit();
      drain();
      idle_on = 0;
      send_byte(8'h00, 1'b1);
      for (int i = 0; i < 16; i++) send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      idle_on = 1;
   endtask

   task automatic test_backpressure();
      drain();
      idle_on = 0;
      rsp_hold_len = 3000;
      random_bytes(30);
      drain();
      idle_on = 1;
      random_bytes(10);
   endtask

   task automatic test_random();
      for (int ph = 0; ph < 6; ph++) begin
         setup(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
               ($urandom_range(0, 2) == 0) ? 24'($urandom_range(1, 40)) : 24'd0);
         idle_on = $urandom_range(0, 3) != 0;
         random_bytes(30);
      end
      idle_on = 1;
   endtask

   // result side stalls
   initial begin
      int stall;
      wait (!reset);
      forever begin
         stall = (rsp_hold_len > 0) ? rsp_hold_len : (idle_on ? $urandom_range(0, 18) : 0);
         rsp_hold_len = 0;
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // compare each accepted sample with the oldest prediction
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_samples.size() == 0) begin
            $display("%0t unexpected sample: got %h", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_samples.pop_front();
            if (rsp_data !== want) begin
               $display("%0t mismatch: expected sample %0d rc %0b done %0b err %0b last %0b",
                        $time, want.sample, want.right_channel, want.stream_done,
                        want.decode_error, want.last_of_byte);
               $display("%0t           actual sample %0d rc %0b done %0b err %0b last %0b",
                        $time, rsp_data.sample, rsp_data.right_channel,
                        rsp_data.stream_done, rsp_data.decode_error, rsp_data.last_of_byte);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      clear_stream();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_byte_extremes();
      test_shift_and_stereo();
      test_frame_limit();
      test_range_overflow();
      test_unary_limit();
      test_backpressure();
      test_random();
      drain();
      if (error_count == 0 && pending_samples.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/apad_pkg.sv
hdl/apad_ctrl.sv
hdl/apad_datapath.sv
hdl/adaptive_predictive_audio_decoder_top.sv
hdl/apad_checker.sv
test/testbench.sv
